@@ sv/olir_pkg.sv @@
// olir_pkg: shared types, codes and sizes for the ordered list block
// used by olir_cell, olir_chain and ordered_list_insert_remove
`timescale 1ns / 1ps

package olir_pkg;

  // store geometry
  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 3;
  localparam int ST_W   = 2;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_APPEND     = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FN_POP        = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FN_INSERT     = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FN_REMOVE_AT  = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FN_REMOVE_VAL = FUNC_W'(4);

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = ST_W'(0);
  localparam logic [ST_W-1:0] ST_EMPTY = ST_W'(1);
  localparam logic [ST_W-1:0] ST_RANGE = ST_W'(2);
  localparam logic [ST_W-1:0] ST_FULL  = ST_W'(3);

  // per-cell source select
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOWER,
    SEL_UPPER,
    SEL_LOAD
  } cell_sel_t;

  // command broadcast to the whole row
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_SWEEP
  } chain_op_t;

  typedef struct packed {
    chain_op_t        op;
    logic [IDX_W-1:0] bound;
    logic             keep;
    logic [VAL_W-1:0] load_data;
  } chain_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic [CNT_W-1:0]        count_after;
    logic [ST_W-1:0]         status;
  } out_beat_t;

endpackage

@@ sv/olir_cell.sv @@
// olir_cell: one storage cell of the list row, takes its neighbor, a new value or holds
// depends on olir_pkg
`timescale 1ns / 1ps

module olir_cell (
  input  logic                           clk,
  input  olir_pkg::cell_sel_t            sel,
  input  logic [olir_pkg::VAL_W-1:0]     lower_data,
  input  logic [olir_pkg::VAL_W-1:0]     upper_data,
  input  logic [olir_pkg::VAL_W-1:0]     load_data,
  output logic [olir_pkg::VAL_W-1:0]     data_q
);

  logic [olir_pkg::VAL_W-1:0] data_r;
  logic [olir_pkg::VAL_W-1:0] data_nxt;

  // source select
  always_comb begin
    case (sel)
      olir_pkg::SEL_LOWER: data_nxt = lower_data;
      olir_pkg::SEL_UPPER: data_nxt = upper_data;
      olir_pkg::SEL_LOAD:  data_nxt = load_data;
      default:             data_nxt = data_r;
    endcase
  end

  // entry register
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

@@ sv/olir_chain.sv @@
// olir_chain: row of cells holding the list, last entry in cell 0, earlier entries above
// depends on olir_pkg and olir_cell
`timescale 1ns / 1ps

module olir_chain (
  input  logic                           clk,
  input  olir_pkg::chain_cmd_t           cmd,
  output logic [olir_pkg::VAL_W-1:0]     head_data
);

  logic [olir_pkg::VAL_W-1:0] cell_q [olir_pkg::DEPTH];

  for (genvar c = 0; c < olir_pkg::DEPTH; c++) begin : g_cell
    olir_pkg::cell_sel_t        sel;
    logic [olir_pkg::VAL_W-1:0] lower_d;
    logic [olir_pkg::VAL_W-1:0] upper_d;

    // neighbor taps, zero past either end
    if (c == 0) begin : g_first
      assign lower_d = '0;
    end else begin : g_lower
      assign lower_d = cell_q[c-1];
    end
    if (c == olir_pkg::DEPTH - 1) begin : g_last
      assign upper_d = '0;
    end else begin : g_upper
      assign upper_d = cell_q[c+1];
    end

    // decode the broadcast command against this cell's place
    always_comb begin
      sel = olir_pkg::SEL_HOLD;
      case (cmd.op)
        olir_pkg::OP_INSERT: begin
          if (olir_pkg::IDX_W'(c) > cmd.bound) begin
            sel = olir_pkg::SEL_LOWER;
          end else if (olir_pkg::IDX_W'(c) == cmd.bound) begin
            sel = olir_pkg::SEL_LOAD;
          end
        end
        olir_pkg::OP_REMOVE: begin
          if (olir_pkg::IDX_W'(c) >= cmd.bound) begin
            sel = olir_pkg::SEL_UPPER;
          end
        end
        olir_pkg::OP_SWEEP: begin
          if (cmd.keep && olir_pkg::IDX_W'(c) == cmd.bound) begin
            sel = olir_pkg::SEL_LOAD;
          end else begin
            sel = olir_pkg::SEL_UPPER;
          end
        end
        default: sel = olir_pkg::SEL_HOLD;
      endcase
    end

    olir_cell u_cell (
      .clk        (clk),
      .sel        (sel),
      .lower_data (lower_d),
      .upper_data (upper_d),
      .load_data  (cmd.load_data),
      .data_q     (cell_q[c])
    );
  end

  assign head_data = cell_q[0];

endmodule

@@ sv/ordered_list_insert_remove.sv @@
// Append, pop, insert and remove at index give their registered result in the cycle after the beat.
// Remove value holds the input and walks the whole list through cell 0, one entry per cycle.
// Throughput: one beat per cycle for all but remove value, unless out_stall holds a result.
// Reset clears the count and the control state; cell contents need no clearing.
// depends on olir_pkg and olir_chain
`timescale 1ns / 1ps

module ordered_list_insert_remove (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  olir_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output olir_pkg::out_beat_t out_data
);

  olir_pkg::state_t            state_r, state_nxt;
  logic [olir_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [olir_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [olir_pkg::CNT_W-1:0]  kept_r, kept_nxt;
  logic [olir_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic                        out_valid_r;
  olir_pkg::out_beat_t         out_data_r;
  olir_pkg::out_beat_t         res;
  olir_pkg::chain_cmd_t        cmd;
  logic [olir_pkg::VAL_W-1:0]  head_data;
  logic                        in_fire;
  logic                        load_out;
  logic                        start_sweep;
  logic                        sweep_last;
  logic [olir_pkg::CMP_W-1:0]  cnt_x;
  logic [olir_pkg::CMP_W-1:0]  pos_x;

  // handshake
  assign in_stall  = (state_r != olir_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cnt_x       = olir_pkg::CMP_W'(count_r);
  assign pos_x       = olir_pkg::CMP_W'(in_data.position);
  assign start_sweep = in_fire && (in_data.func == olir_pkg::FN_REMOVE_VAL) && (count_r != '0);
  assign sweep_last  = (state_r == olir_pkg::S_SWEEP) && (rem_r == olir_pkg::CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olir_pkg::S_IDLE:  if (start_sweep) state_nxt = olir_pkg::S_SWEEP;
      olir_pkg::S_SWEEP: if (sweep_last) state_nxt = olir_pkg::S_IDLE;
      default:           state_nxt = olir_pkg::S_IDLE;
    endcase
  end

  // command, result and count update
  always_comb begin
    cmd.op        = olir_pkg::OP_HOLD;
    cmd.bound     = '0;
    cmd.keep      = 1'b0;
    cmd.load_data = in_data.item_value;
    res.popped_value = '0;
    res.count_after  = count_r;
    res.status       = olir_pkg::ST_OK;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    kept_nxt  = kept_r;
    val_nxt   = val_r;
    load_out  = 1'b0;
    case (state_r)
      olir_pkg::S_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          case (in_data.func)
            olir_pkg::FN_APPEND: begin
              if (count_r >= olir_pkg::CNT_W'(olir_pkg::DEPTH)) begin
                res.status = olir_pkg::ST_FULL;
              end else begin
                cmd.op    = olir_pkg::OP_INSERT;
                count_nxt = count_r + olir_pkg::CNT_W'(1);
              end
            end
            olir_pkg::FN_POP: begin
              if (count_r == '0) begin
                res.popped_value = '1;
                res.status       = olir_pkg::ST_EMPTY;
              end else begin
                cmd.op           = olir_pkg::OP_REMOVE;
                res.popped_value = head_data;
                count_nxt        = count_r - olir_pkg::CNT_W'(1);
              end
            end
            olir_pkg::FN_INSERT: begin
              if (pos_x > cnt_x) begin
                res.status = olir_pkg::ST_RANGE;
              end else if (count_r >= olir_pkg::CNT_W'(olir_pkg::DEPTH)) begin
                res.status = olir_pkg::ST_FULL;
              end else begin
                cmd.op    = olir_pkg::OP_INSERT;
                cmd.bound = olir_pkg::IDX_W'(cnt_x - pos_x);
                count_nxt = count_r + olir_pkg::CNT_W'(1);
              end
            end
            olir_pkg::FN_REMOVE_AT: begin
              if (pos_x >= cnt_x) begin
                res.status = olir_pkg::ST_RANGE;
              end else begin
                cmd.op    = olir_pkg::OP_REMOVE;
                cmd.bound = olir_pkg::IDX_W'(cnt_x - olir_pkg::CMP_W'(1) - pos_x);
                count_nxt = count_r - olir_pkg::CNT_W'(1);
              end
            end
            olir_pkg::FN_REMOVE_VAL: begin
              if (count_r == '0) begin
                res.status = olir_pkg::ST_EMPTY;
              end else begin
                // walk starts; result comes at its end
                load_out = 1'b0;
                rem_nxt  = count_r;
                kept_nxt = '0;
                val_nxt  = in_data.item_value;
              end
            end
            default: res.status = olir_pkg::ST_OK;
          endcase
          res.count_after = count_nxt;
        end
      end
      olir_pkg::S_SWEEP: begin
        // cell 0 leaves the row; survivors are placed above the unvisited part
        cmd.op        = olir_pkg::OP_SWEEP;
        cmd.keep      = (head_data != val_r);
        cmd.load_data = head_data;
        cmd.bound     = olir_pkg::IDX_W'(rem_r - olir_pkg::CNT_W'(1) + kept_r);
        rem_nxt       = rem_r - olir_pkg::CNT_W'(1);
        kept_nxt      = kept_r + olir_pkg::CNT_W'(cmd.keep);
        if (sweep_last) begin
          load_out        = 1'b1;
          count_nxt       = kept_nxt;
          res.count_after = kept_nxt;
        end
      end
      default: cmd.op = olir_pkg::OP_HOLD;
    endcase
  end

  olir_chain u_chain (
    .clk       (clk),
    .cmd       (cmd),
    .head_data (head_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olir_pkg::S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      kept_r  <= kept_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (load_out) begin
      out_data_r <= res;
    end
  end

  // count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= olir_pkg::CNT_W'(olir_pkg::DEPTH))
    else $error("entry count beyond store depth");

  // no result is pending while the walk runs
  a_sweep_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olir_pkg::S_SWEEP) |-> !out_valid_r)
    else $error("result pending during remove value walk");

  // walk never runs with nothing left to visit, nor tracks more entries than the count
  a_sweep_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olir_pkg::S_SWEEP) |-> (rem_r != '0) && (rem_r + kept_r <= count_r))
    else $error("remove value walk bookkeeping broken");

  // a pop from a non-empty list drops the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.func == olir_pkg::FN_POP && count_r != '0)
    |=> (out_data_r.count_after == $past(count_r) - olir_pkg::CNT_W'(1)) && out_valid_r)
    else $error("pop result count mismatch");

endmodule
